FILE: rtl/mic_pkg.sv
// Shared types and constants for the MIPS-I integer core.
// Opcode, function and status codes; controller/datapath interface structs.
// No dependencies.
package mic_pkg;

  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_REGIMM  = 6'h01;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_BLEZ    = 6'h06;
  localparam logic [5:0] OP_BGTZ    = 6'h07;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDI_U  = 6'h09;
  localparam logic [5:0] OP_SLTI    = 6'h0A;
  localparam logic [5:0] OP_SLTIU   = 6'h0B;
  localparam logic [5:0] OP_ANDI    = 6'h0C;
  localparam logic [5:0] OP_ORI     = 6'h0D;
  localparam logic [5:0] OP_XORI    = 6'h0E;
  localparam logic [5:0] OP_LUI     = 6'h0F;
  localparam logic [5:0] OP_LB      = 6'h20;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_SB      = 6'h28;
  localparam logic [5:0] OP_SW      = 6'h2B;

  localparam logic [5:0] FN_SLL     = 6'h00;
  localparam logic [5:0] FN_SRL     = 6'h02;
  localparam logic [5:0] FN_SRA     = 6'h03;
  localparam logic [5:0] FN_SLLV    = 6'h04;
  localparam logic [5:0] FN_SRLV    = 6'h06;
  localparam logic [5:0] FN_SRAV    = 6'h07;
  localparam logic [5:0] FN_JR      = 6'h08;
  localparam logic [5:0] FN_SYSCALL = 6'h0C;
  localparam logic [5:0] FN_BREAK   = 6'h0D;
  localparam logic [5:0] FN_MFHI    = 6'h10;
  localparam logic [5:0] FN_MFLO    = 6'h12;
  localparam logic [5:0] FN_MULT    = 6'h18;
  localparam logic [5:0] FN_MULTU   = 6'h19;
  localparam logic [5:0] FN_DIV     = 6'h1A;
  localparam logic [5:0] FN_DIVU    = 6'h1B;
  localparam logic [5:0] FN_ADD     = 6'h20;
  localparam logic [5:0] FN_ADDU    = 6'h21;
  localparam logic [5:0] FN_SUB     = 6'h22;
  localparam logic [5:0] FN_SUBU    = 6'h23;
  localparam logic [5:0] FN_AND     = 6'h24;
  localparam logic [5:0] FN_OR      = 6'h25;
  localparam logic [5:0] FN_XOR     = 6'h26;
  localparam logic [5:0] FN_SLT     = 6'h2A;
  localparam logic [5:0] FN_SLTU    = 6'h2B;

  localparam logic [4:0] RT_BLTZ    = 5'h00;
  localparam logic [4:0] RT_BGEZ    = 5'h01;
  localparam logic [4:0] RT_BLTZAL  = 5'h10;
  localparam logic [4:0] RT_BGEZAL  = 5'h11;

  localparam logic [4:0] REG_ZERO   = 5'd0;
  localparam logic [4:0] REG_V0     = 5'd2;
  localparam logic [4:0] REG_A0     = 5'd4;
  localparam logic [4:0] REG_RA     = 5'd31;

  localparam logic [31:0] SYS_EXIT  = 32'd10;
  localparam logic [31:0] JMP_MASK  = 32'hF0000000;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_HOST    = 3'd1;
  localparam logic [2:0] ST_EXIT    = 3'd2;
  localparam logic [2:0] ST_ILLEGAL = 3'd3;
  localparam logic [2:0] ST_FAULT   = 3'd4;
  localparam logic [2:0] ST_HALTED  = 3'd5;

  localparam logic [0:0] CFG_START_PC  = 1'b0;
  localparam logic [0:0] CFG_DATA_BASE = 1'b1;

  localparam logic [31:0] START_PC_RST  = 32'h00400000;
  localparam logic [31:0] DATA_BASE_RST = 32'h10010000;

  typedef struct packed {
    logic clear;   // memory clearing pass
    logic fetch;   // latch instruction, read register file
    logic exec;    // decode/execute, issue memory read
    logic mem;     // memory data back: load value / store write
    logic commit;  // architectural update, load output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic need_mem;
    logic need_md;
    logic md_busy;
    logic out_free;
  } dp_stat_t;

  typedef struct packed {
    logic start;
    logic div;
    logic sgn;
  } md_cmd_t;

endpackage

FILE: rtl/mic_muldiv.sv
// Iterative multiply/divide unit: one bit per cycle.
// Depends on mic_pkg.
module mic_muldiv (
  input  logic             clk,
  input  logic             rst,
  input  mic_pkg::md_cmd_t cmd,
  input  logic [31:0]      a,
  input  logic [31:0]      b,
  output logic             busy,
  output logic [31:0]      hi_out,
  output logic [31:0]      lo_out
);

  logic [63:0] p;
  logic [31:0] mcand;
  logic [4:0]  cnt;
  logic        is_div;
  logic        neg_q;
  logic        neg_r;

  logic [31:0] ma;
  logic [31:0] mb;
  logic [32:0] msum;
  logic [32:0] dshift;
  logic [32:0] ddiff;
  logic [63:0] prod;
  logic [31:0] quo;
  logic [31:0] rem;

  always_comb begin
    ma = (cmd.sgn && a[31]) ? 32'(0 - a) : a;
    mb = (cmd.sgn && b[31]) ? 32'(0 - b) : b;
    msum = {1'b0, p[63:32]} + (p[0] ? {1'b0, mcand} : 33'd0);
    dshift = {p[63:32], p[31]};
    ddiff = dshift - {1'b0, mcand};
    prod = neg_q ? 64'(0 - p) : p;
    quo = neg_q ? 32'(0 - p[31:0]) : p[31:0];
    rem = neg_r ? 32'(0 - p[63:32]) : p[63:32];
    hi_out = is_div ? rem : prod[63:32];
    lo_out = is_div ? quo : prod[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (cmd.start) begin
      busy <= 1'b1;
      cnt <= '0;
    end else if (busy) begin
      cnt <= cnt + 5'd1;
      if (cnt == 5'd31) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      is_div <= cmd.div;
      neg_q <= cmd.sgn && (a[31] ^ b[31]);
      neg_r <= cmd.sgn && a[31];
      p <= cmd.div ? {32'd0, ma} : {32'd0, mb};
      mcand <= cmd.div ? mb : ma;
    end else if (busy) begin
      if (is_div) begin
        if (!ddiff[32]) begin
          p <= {ddiff[31:0], p[30:0], 1'b1};
        end else begin
          p <= {dshift[31:0], p[30:0], 1'b0};
        end
      end else begin
        p <= {msum, p[31:1]};
      end
    end
  end

endmodule

FILE: rtl/mic_dpath.sv
// Datapath: PC, register file, hi/lo, data memory, ALU/decode and output register.
// Depends on mic_pkg and mic_muldiv.
module mic_dpath #(
  parameter int DMEM_WORDS = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  mic_pkg::ctrl_cmd_t    cmd,
  output mic_pkg::dp_stat_t     stat,
  input  logic                  cfg_write,
  input  logic [0:0]            cfg_index,
  input  logic [31:0]           cfg_data,
  input  logic [31:0]           instruction,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [31:0]           next_pc,
  output logic [2:0]            status,
  output logic [31:0]           service,
  output logic [31:0]           argument,
  output logic                  reg_written,
  output logic [4:0]            reg_index,
  output logic [31:0]           reg_value,
  output logic                  overflow,
  output logic                  div_by_zero
);

  localparam int AW = (DMEM_WORDS > 1) ? $clog2(DMEM_WORDS) : 1;
  localparam logic [31:0] DMEM_BYTES = 32'(DMEM_WORDS * 4);
  localparam logic [AW-1:0] LAST_IDX = AW'(DMEM_WORDS - 1);

  logic [31:0] start_pc;
  logic [31:0] data_base;
  logic [31:0] pc;
  logic [31:0] hi;
  logic [31:0] lo;
  logic        halted;
  logic [31:0] instr;
  logic [31:0] v0;
  logic [31:0] a0;

  logic [31:0] rf [32];
  logic [31:0] rf_valid;
  logic [31:0] ra_q;
  logic [31:0] rb_q;
  logic        ra_v;
  logic        rb_v;

  logic [31:0] dmem [DMEM_WORDS];
  logic [31:0] dm_rdata;
  logic [AW-1:0] clr_cnt;

  // result of the current request
  logic [31:0] r_npc;
  logic [2:0]  r_status;
  logic [31:0] r_service;
  logic [31:0] r_arg;
  logic        r_wr;
  logic [4:0]  r_wi;
  logic [31:0] r_wv;
  logic        r_ovf;
  logic        r_dz;
  logic        r_md;
  logic [AW-1:0] r_idx;
  logic [1:0]  r_bs;

  logic [5:0]  op;
  logic [4:0]  rs;
  logic [4:0]  rt;
  logic [4:0]  rd;
  logic [4:0]  sh;
  logic [5:0]  fn;
  logic [31:0] a;
  logic [31:0] b;
  logic [31:0] imm;
  logic [31:0] zimm;
  logic [31:0] pc4;
  logic [31:0] target;
  logic [31:0] addr;
  logic [31:0] off;
  logic        fault;

  logic [31:0] e_npc;
  logic [2:0]  e_status;
  logic [31:0] e_service;
  logic [31:0] e_arg;
  logic        e_wr;
  logic [4:0]  e_wi;
  logic [31:0] e_wv;
  logic        e_ovf;
  logic        e_dz;
  logic        e_mem;
  logic        e_md;
  mic_pkg::md_cmd_t md_cmd;

  logic        md_busy;
  logic [31:0] md_hi;
  logic [31:0] md_lo;

  logic [7:0]  ld_byte;
  logic [31:0] st_word;

  always_comb begin
    op = instr[31:26];
    rs = instr[25:21];
    rt = instr[20:16];
    rd = instr[15:11];
    sh = instr[10:6];
    fn = instr[5:0];
    a = ra_v ? ra_q : 32'd0;
    b = rb_v ? rb_q : 32'd0;
    imm = {{16{instr[15]}}, instr[15:0]};
    zimm = {16'd0, instr[15:0]};
    pc4 = pc + 32'd4;
    target = pc4 + {imm[29:0], 2'b00};
    addr = a + imm;
    off = addr - data_base;
    fault = (((op == mic_pkg::OP_LW) || (op == mic_pkg::OP_SW)) && (off[1:0] != 2'b00))
            || (off >= DMEM_BYTES);
  end

  // decode and execute
  always_comb begin
    e_npc = pc4;
    e_status = mic_pkg::ST_OK;
    e_service = 32'd0;
    e_arg = 32'd0;
    e_wr = 1'b0;
    e_wi = mic_pkg::REG_ZERO;
    e_wv = 32'd0;
    e_ovf = 1'b0;
    e_dz = 1'b0;
    e_mem = 1'b0;
    e_md = 1'b0;
    md_cmd.div = 1'b0;
    md_cmd.sgn = 1'b0;
    if (halted) begin
      e_status = mic_pkg::ST_HALTED;
      e_npc = pc;
    end else if (op == mic_pkg::OP_SPECIAL) begin
      e_wi = rd;
      case (fn)
        mic_pkg::FN_ADD: begin
          e_wv = a + b; e_wr = 1'b1;
          e_ovf = ~(a[31] ^ b[31]) & (a[31] ^ e_wv[31]);
        end
        mic_pkg::FN_SUB: begin
          e_wv = a - b; e_wr = 1'b1;
          e_ovf = (a[31] ^ b[31]) & (a[31] ^ e_wv[31]);
        end
        mic_pkg::FN_ADDU: begin e_wv = a + b; e_wr = 1'b1; end
        mic_pkg::FN_SUBU: begin e_wv = a - b; e_wr = 1'b1; end
        mic_pkg::FN_AND:  begin e_wv = a & b; e_wr = 1'b1; end
        mic_pkg::FN_OR:   begin e_wv = a | b; e_wr = 1'b1; end
        mic_pkg::FN_XOR:  begin e_wv = a ^ b; e_wr = 1'b1; end
        mic_pkg::FN_SLT: begin
          e_wv = {31'd0, $signed(a) < $signed(b)}; e_wr = 1'b1;
        end
        mic_pkg::FN_SLTU: begin e_wv = {31'd0, a < b}; e_wr = 1'b1; end
        mic_pkg::FN_SLL:  begin e_wv = b << sh; e_wr = 1'b1; end
        mic_pkg::FN_SRL:  begin e_wv = b >> sh; e_wr = 1'b1; end
        mic_pkg::FN_SRA:  begin e_wv = 32'($signed(b) >>> sh); e_wr = 1'b1; end
        mic_pkg::FN_SLLV: begin e_wv = b << a[4:0]; e_wr = 1'b1; end
        mic_pkg::FN_SRLV: begin e_wv = b >> a[4:0]; e_wr = 1'b1; end
        mic_pkg::FN_SRAV: begin e_wv = 32'($signed(b) >>> a[4:0]); e_wr = 1'b1; end
        mic_pkg::FN_MULT: begin e_md = 1'b1; md_cmd.sgn = 1'b1; end
        mic_pkg::FN_MULTU: e_md = 1'b1;
        mic_pkg::FN_DIV: begin
          md_cmd.div = 1'b1; md_cmd.sgn = 1'b1;
          if (b == 32'd0) e_dz = 1'b1;
          else e_md = 1'b1;
        end
        mic_pkg::FN_DIVU: begin
          md_cmd.div = 1'b1;
          if (b == 32'd0) e_dz = 1'b1;
          else e_md = 1'b1;
        end
        mic_pkg::FN_MFHI: begin e_wv = hi; e_wr = 1'b1; end
        mic_pkg::FN_MFLO: begin e_wv = lo; e_wr = 1'b1; end
        mic_pkg::FN_JR: e_npc = a;
        mic_pkg::FN_BREAK: ;
        mic_pkg::FN_SYSCALL: begin
          if (v0 == mic_pkg::SYS_EXIT) begin
            e_status = mic_pkg::ST_EXIT; e_npc = pc;
          end else begin
            e_status = mic_pkg::ST_HOST; e_service = v0; e_arg = a0;
          end
        end
        default: begin e_status = mic_pkg::ST_ILLEGAL; e_npc = pc; end
      endcase
    end else begin
      e_wi = rt;
      case (op)
        mic_pkg::OP_ADDI_U: begin e_wv = a + imm; e_wr = 1'b1; end
        mic_pkg::OP_ADDI: begin
          e_wv = a + imm; e_wr = 1'b1;
          e_ovf = ~(a[31] ^ imm[31]) & (a[31] ^ e_wv[31]);
        end
        mic_pkg::OP_ANDI: begin e_wv = a & zimm; e_wr = 1'b1; end
        mic_pkg::OP_ORI:  begin e_wv = a | zimm; e_wr = 1'b1; end
        mic_pkg::OP_XORI: begin e_wv = a ^ zimm; e_wr = 1'b1; end
        mic_pkg::OP_SLTI: begin
          e_wv = {31'd0, $signed(a) < $signed(imm)}; e_wr = 1'b1;
        end
        mic_pkg::OP_SLTIU: begin e_wv = {31'd0, a < imm}; e_wr = 1'b1; end
        mic_pkg::OP_LUI: begin e_wv = {instr[15:0], 16'd0}; e_wr = 1'b1; end
        mic_pkg::OP_LW, mic_pkg::OP_LB, mic_pkg::OP_SW, mic_pkg::OP_SB: begin
          if (fault) begin
            e_status = mic_pkg::ST_FAULT; e_npc = pc;
          end else begin
            e_mem = 1'b1;
            e_wr = (op == mic_pkg::OP_LW) || (op == mic_pkg::OP_LB);
          end
        end
        mic_pkg::OP_BEQ: if (a == b) e_npc = target;
        mic_pkg::OP_BNE: if (a != b) e_npc = target;
        mic_pkg::OP_BLEZ: begin
          if (rt != 5'd0) begin
            e_status = mic_pkg::ST_ILLEGAL; e_npc = pc;
          end else if (a == 32'd0 || a[31]) begin
            e_npc = target;
          end
        end
        mic_pkg::OP_BGTZ: begin
          if (rt != 5'd0) begin
            e_status = mic_pkg::ST_ILLEGAL; e_npc = pc;
          end else if (a != 32'd0 && !a[31]) begin
            e_npc = target;
          end
        end
        mic_pkg::OP_REGIMM: begin
          case (rt)
            mic_pkg::RT_BLTZ: if (a[31]) e_npc = target;
            mic_pkg::RT_BGEZ: if (!a[31]) e_npc = target;
            mic_pkg::RT_BLTZAL, mic_pkg::RT_BGEZAL: begin
              // link is written whether or not the branch goes
              e_wv = pc4; e_wi = mic_pkg::REG_RA; e_wr = 1'b1;
              if ((rt == mic_pkg::RT_BLTZAL) == a[31]) e_npc = target;
            end
            default: begin e_status = mic_pkg::ST_ILLEGAL; e_npc = pc; end
          endcase
        end
        mic_pkg::OP_J, mic_pkg::OP_JAL: begin
          e_npc = (pc4 & mic_pkg::JMP_MASK) | {4'd0, instr[25:0], 2'b00};
          if (op == mic_pkg::OP_JAL) begin
            e_wv = pc4; e_wi = mic_pkg::REG_RA; e_wr = 1'b1;
          end
        end
        default: begin e_status = mic_pkg::ST_ILLEGAL; e_npc = pc; end
      endcase
    end
    if (!e_wr || e_wi == mic_pkg::REG_ZERO) begin
      e_wr = 1'b0;
      e_wi = mic_pkg::REG_ZERO;
      e_wv = 32'd0;
    end
    md_cmd.start = cmd.exec && e_md;
  end

  always_comb begin
    case (r_bs)
      2'd0: ld_byte = dm_rdata[7:0];
      2'd1: ld_byte = dm_rdata[15:8];
      2'd2: ld_byte = dm_rdata[23:16];
      default: ld_byte = dm_rdata[31:24];
    endcase
    st_word = dm_rdata;
    if (instr[31:26] == mic_pkg::OP_SW) begin
      st_word = b;
    end else begin
      case (r_bs)
        2'd0: st_word[7:0] = b[7:0];
        2'd1: st_word[15:8] = b[7:0];
        2'd2: st_word[23:16] = b[7:0];
        default: st_word[31:24] = b[7:0];
      endcase
    end
  end

  mic_muldiv u_md (
    .clk    (clk),
    .rst    (rst),
    .cmd    (md_cmd),
    .a      (a),
    .b      (b),
    .busy   (md_busy),
    .hi_out (md_hi),
    .lo_out (md_lo)
  );

  // data memory: one write port (clear or store), one registered read
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      dmem[clr_cnt] <= 32'd0;
    end else if (cmd.mem && !r_wr && !(r_wi != mic_pkg::REG_ZERO)
                 && ((op == mic_pkg::OP_SW) || (op == mic_pkg::OP_SB))) begin
      dmem[r_idx] <= st_word;
    end
    if (cmd.exec) begin
      dm_rdata <= dmem[off[AW+1:2]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear) begin
      clr_cnt <= clr_cnt + AW'(1);
    end
  end

  // register file
  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      ra_q <= rf[instruction[25:21]];
      rb_q <= rf[instruction[20:16]];
    end
    if (cmd.commit && r_wr) begin
      rf[r_wi] <= r_wv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rf_valid <= '0;
      ra_v <= 1'b0;
      rb_v <= 1'b0;
      v0 <= 32'd0;
      a0 <= 32'd0;
    end else begin
      if (cmd.fetch) begin
        ra_v <= rf_valid[instruction[25:21]];
        rb_v <= rf_valid[instruction[20:16]];
      end
      if (cmd.commit && r_wr) begin
        rf_valid[r_wi] <= 1'b1;
        if (r_wi == mic_pkg::REG_V0) v0 <= r_wv;
        if (r_wi == mic_pkg::REG_A0) a0 <= r_wv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      instr <= instruction;
    end
    if (cmd.exec) begin
      r_npc <= e_npc;
      r_status <= e_status;
      r_service <= e_service;
      r_arg <= e_arg;
      r_wr <= e_wr;
      r_wi <= e_wi;
      r_wv <= e_wv;
      r_ovf <= e_ovf;
      r_dz <= e_dz;
      r_md <= e_md;
      r_idx <= off[AW+1:2];
      r_bs <= off[1:0];
    end else if (cmd.mem && r_wr) begin
      if (op == mic_pkg::OP_LW) begin
        r_wv <= dm_rdata;
      end else begin
        r_wv <= {{24{ld_byte[7]}}, ld_byte};
      end
    end
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      start_pc <= mic_pkg::START_PC_RST;
      data_base <= mic_pkg::DATA_BASE_RST;
      pc <= mic_pkg::START_PC_RST;
      hi <= 32'd0;
      lo <= 32'd0;
      halted <= 1'b0;
    end else if (cfg_write) begin
      if (cfg_index == mic_pkg::CFG_START_PC) begin
        start_pc <= cfg_data;
        pc <= cfg_data;
      end else begin
        data_base <= cfg_data;
      end
    end else if (cmd.commit) begin
      pc <= r_npc;
      if (r_md) begin
        hi <= md_hi;
        lo <= md_lo;
      end
      if (r_status == mic_pkg::ST_EXIT || r_status == mic_pkg::ST_ILLEGAL
          || r_status == mic_pkg::ST_FAULT) begin
        halted <= 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      next_pc <= r_npc;
      status <= r_status;
      service <= r_service;
      argument <= r_arg;
      reg_written <= r_wr;
      reg_index <= r_wi;
      reg_value <= r_wv;
      overflow <= r_ovf;
      div_by_zero <= r_dz;
    end
  end

  always_comb begin
    stat.clear_done = (clr_cnt == LAST_IDX);
    stat.need_mem = e_mem;
    stat.need_md = e_md;
    stat.md_busy = md_busy;
    stat.out_free = !out_valid || !out_stall;
  end

  logic unused_start_pc;
  assign unused_start_pc = ^start_pc;

endmodule

FILE: rtl/mic_ctrl.sv
// Sequencing state machine for the core: clear, fetch, execute, memory,
// multiply/divide wait and commit. Depends on mic_pkg.
module mic_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  mic_pkg::dp_stat_t  stat,
  output mic_pkg::ctrl_cmd_t cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_MEM   = 3'd3;
  localparam logic [2:0] S_MD    = 3'd4;
  localparam logic [2:0] S_WB    = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    in_stall = 1'b1;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.fetch = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (stat.need_mem) state_next = S_MEM;
        else if (stat.need_md) state_next = S_MD;
        else state_next = S_WB;
      end
      S_MEM: begin
        cmd.mem = 1'b1;
        state_next = S_WB;
      end
      S_MD: begin
        if (!stat.md_busy) state_next = S_WB;
      end
      S_WB: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/mips_integer_core_step_core.sv
// MIPS-I integer core, one instruction per request, no delay slots.
// After reset the data memory is cleared, one word a cycle, before the
// first request is taken. A request then passes accept, execute and
// commit; loads and stores add a memory step (registered memory read),
// and mult/multu/div/divu a wait on the bit-serial multiply/divide unit
// (a divide by zero skips the unit). Output stalls hold the commit.
// One request is in flight at a time; a finished result sits in the output
// register while the next request is accepted. Depends on mic_pkg,
// mic_ctrl, mic_dpath and mic_muldiv.
module mips_integer_core_step_core #(
  parameter int DMEM_WORDS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] instruction,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] next_pc,
  output logic [2:0]  status,
  output logic [31:0] service,
  output logic [31:0] argument,
  output logic        reg_written,
  output logic [4:0]  reg_index,
  output logic [31:0] reg_value,
  output logic        overflow,
  output logic        div_by_zero
);

  mic_pkg::ctrl_cmd_t cmd;
  mic_pkg::dp_stat_t  stat;

  mic_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  mic_dpath #(
    .DMEM_WORDS (DMEM_WORDS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .instruction (instruction),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .next_pc     (next_pc),
    .status      (status),
    .service     (service),
    .argument    (argument),
    .reg_written (reg_written),
    .reg_index   (reg_index),
    .reg_value   (reg_value),
    .overflow    (overflow),
    .div_by_zero (div_by_zero)
  );

endmodule

FILE: rtl/mic_checker.sv
// Port-level checks for the MIPS-I core, bound to the top level.
// Depends on mic_pkg and mips_integer_core_step_core.
module mic_checker (
  input logic        clk,
  input logic        rst,
  input logic        cfg_write,
  input logic [0:0]  cfg_index,
  input logic [31:0] cfg_data,
  input logic        in_valid,
  input logic        in_stall,
  input logic [31:0] instruction,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] next_pc,
  input logic [2:0]  status,
  input logic [31:0] service,
  input logic [31:0] argument,
  input logic        reg_written,
  input logic [4:0]  reg_index,
  input logic [31:0] reg_value,
  input logic        overflow,
  input logic        div_by_zero
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present after reset");

  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !reg_written |-> reg_index == 5'd0 && reg_value == 32'd0)
    else $error("register fields set without a write");

  a_host_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != mic_pkg::ST_HOST |-> service == 32'd0 && argument == 32'd0)
    else $error("syscall fields set outside host status");

  a_halted_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == mic_pkg::ST_HALTED || status == mic_pkg::ST_ILLEGAL
                  || status == mic_pkg::ST_FAULT || status == mic_pkg::ST_EXIT)
    |-> !reg_written && !overflow && !div_by_zero)
    else $error("side effect reported on a stopping request");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken before commit");

endmodule

bind mips_integer_core_step_core mic_checker u_chk (.*);

FILE: sim/tb_mips_integer_core_step_core.sv
// Testbench for mips_integer_core_step_core: instruction requests against a
// behavioral model of the MIPS-I core, directed table then random programs.
// Depends on mic_pkg and the core RTL.
module tb_mips_integer_core_step_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DMEM_WORDS = 1024;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [31:0] npc;
    logic [2:0]  status;
    logic [31:0] service;
    logic [31:0] argument;
    logic        wr;
    logic [4:0]  idx;
    logic [31:0] val;
    logic        ovf;
    logic        dz;
  } outcome_t;

  typedef struct {
    logic [31:0] word;
    bit          known;
    logic [2:0]  st;
    logic [31:0] val;
  } dir_row_t;

  logic        clk, rst;
  logic        cfg_write;
  logic [0:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid, in_stall;
  logic [31:0] instruction;
  logic        out_valid, out_stall;
  logic [31:0] next_pc, service, argument, reg_value;
  logic [2:0]  status;
  logic        reg_written, overflow, div_by_zero;
  logic [4:0]  reg_index;

  mips_integer_core_step_core #(.DMEM_WORDS(DMEM_WORDS)) u_dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .instruction(instruction),
    .out_valid(out_valid), .out_stall(out_stall),
    .next_pc(next_pc), .status(status), .service(service), .argument(argument),
    .reg_written(reg_written), .reg_index(reg_index), .reg_value(reg_value),
    .overflow(overflow), .div_by_zero(div_by_zero)
  );

  // core state as the testbench sees it
  logic [31:0] arch_pc, dbase;
  logic [31:0] gpr [32];
  logic [31:0] hi_q, lo_q;
  logic [31:0] dmem [DMEM_WORDS];
  bit          halted;

  outcome_t    pending_results[$];
  int          errors;
  int          sent;
  int          accepted;
  bit          hold_req;
  int          hold_cnt;
  int          stall_left;
  dir_row_t    dir_rows[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("tb_mips_integer_core_step_core failed");
    $finish;
  end

  function automatic logic [31:0] enc_r(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
                                        logic [4:0] rd, logic [4:0] sh);
    return {mic_pkg::OP_SPECIAL, rs, rt, rd, sh, fn};
  endfunction

  function automatic logic [31:0] enc_i(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                        logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  task automatic core_step(input logic [31:0] w, input bit apply, output outcome_t r);
    logic [5:0]  op, fn;
    logic [4:0]  rs, rt, rd, sh;
    logic [31:0] a, b, imm, zimm, target, addr, off, cur, nhi, nlo, q, rm, ma, mb, mval;
    logic [63:0] p;
    logic [9:0]  widx;
    int          lane;
    logic        memw;
    op = w[31:26]; rs = w[25:21]; rt = w[20:16]; rd = w[15:11]; sh = w[10:6]; fn = w[5:0];
    a = gpr[rs]; b = gpr[rt];
    imm = {{16{w[15]}}, w[15:0]};
    zimm = {16'h0, w[15:0]};
    r = '0;
    r.npc = arch_pc + 32'd4;
    nhi = hi_q; nlo = lo_q; memw = 1'b0; widx = '0; mval = '0;
    if (halted) begin
      r.status = mic_pkg::ST_HALTED; r.npc = arch_pc;
    end else if (op == mic_pkg::OP_SPECIAL) begin
      r.idx = rd; r.wr = 1'b1;
      case (fn)
        mic_pkg::FN_ADD: begin
          r.val = a + b; r.ovf = ~(a[31] ^ b[31]) & (a[31] ^ r.val[31]);
        end
        mic_pkg::FN_SUB: begin
          r.val = a - b; r.ovf = (a[31] ^ b[31]) & (a[31] ^ r.val[31]);
        end
        mic_pkg::FN_ADDU: r.val = a + b;
        mic_pkg::FN_SUBU: r.val = a - b;
        mic_pkg::FN_AND:  r.val = a & b;
        mic_pkg::FN_OR:   r.val = a | b;
        mic_pkg::FN_XOR:  r.val = a ^ b;
        mic_pkg::FN_SLT:  r.val = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
        mic_pkg::FN_SLTU: r.val = (a < b) ? 32'd1 : 32'd0;
        mic_pkg::FN_SLL:  r.val = b << sh;
        mic_pkg::FN_SRL:  r.val = b >> sh;
        mic_pkg::FN_SRA:  r.val = $signed(b) >>> sh;
        mic_pkg::FN_SLLV: r.val = b << a[4:0];
        mic_pkg::FN_SRLV: r.val = b >> a[4:0];
        mic_pkg::FN_SRAV: r.val = $signed(b) >>> a[4:0];
        mic_pkg::FN_MFHI: r.val = hi_q;
        mic_pkg::FN_MFLO: r.val = lo_q;
        default: begin
          r.wr = 1'b0;
          case (fn)
            mic_pkg::FN_MULT: begin
              p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
              nhi = p[63:32]; nlo = p[31:0];
            end
            mic_pkg::FN_MULTU: begin
              p = {32'h0, a} * {32'h0, b};
              nhi = p[63:32]; nlo = p[31:0];
            end
            mic_pkg::FN_DIV: begin
              if (b == 32'h0) r.dz = 1'b1;
              else begin
                ma = a[31] ? -a : a;
                mb = b[31] ? -b : b;
                q = ma / mb; rm = ma % mb;
                nlo = (a[31] != b[31]) ? -q : q;
                nhi = a[31] ? -rm : rm;
              end
            end
            mic_pkg::FN_DIVU: begin
              if (b == 32'h0) r.dz = 1'b1;
              else begin
                nlo = a / b; nhi = a % b;
              end
            end
            mic_pkg::FN_JR: r.npc = a;
            mic_pkg::FN_BREAK: ;
            mic_pkg::FN_SYSCALL: begin
              if (gpr[mic_pkg::REG_V0] == mic_pkg::SYS_EXIT) begin
                r.status = mic_pkg::ST_EXIT; r.npc = arch_pc;
              end else begin
                r.status = mic_pkg::ST_HOST;
                r.service = gpr[mic_pkg::REG_V0];
                r.argument = gpr[mic_pkg::REG_A0];
              end
            end
            default: begin
              r.status = mic_pkg::ST_ILLEGAL; r.npc = arch_pc;
            end
          endcase
        end
      endcase
    end else begin
      target = arch_pc + 32'd4 + (imm << 2);
      addr = a + imm;
      case (op)
        mic_pkg::OP_ADDI_U: begin r.val = a + imm; r.idx = rt; r.wr = 1'b1; end
        mic_pkg::OP_ADDI: begin
          r.val = a + imm; r.idx = rt; r.wr = 1'b1;
          r.ovf = ~(a[31] ^ imm[31]) & (a[31] ^ r.val[31]);
        end
        mic_pkg::OP_ANDI: begin r.val = a & zimm; r.idx = rt; r.wr = 1'b1; end
        mic_pkg::OP_ORI:  begin r.val = a | zimm; r.idx = rt; r.wr = 1'b1; end
        mic_pkg::OP_XORI: begin r.val = a ^ zimm; r.idx = rt; r.wr = 1'b1; end
        mic_pkg::OP_SLTI: begin
          r.val = ($signed(a) < $signed(imm)) ? 32'd1 : 32'd0; r.idx = rt; r.wr = 1'b1;
        end
        mic_pkg::OP_SLTIU: begin
          r.val = (a < imm) ? 32'd1 : 32'd0; r.idx = rt; r.wr = 1'b1;
        end
        mic_pkg::OP_LUI: begin r.val = {w[15:0], 16'h0}; r.idx = rt; r.wr = 1'b1; end
        mic_pkg::OP_LW, mic_pkg::OP_SW, mic_pkg::OP_LB, mic_pkg::OP_SB: begin
          off = addr - dbase;
          if (((op == mic_pkg::OP_LW || op == mic_pkg::OP_SW) && off[1:0] != 2'b00) ||
              off >= DMEM_WORDS * 4) begin
            r.status = mic_pkg::ST_FAULT; r.npc = arch_pc;
          end else begin
            widx = off[11:2];
            cur = dmem[widx];
            lane = int'(off[1:0]);
            case (op)
              mic_pkg::OP_LW: begin r.val = cur; r.idx = rt; r.wr = 1'b1; end
              mic_pkg::OP_SW: begin memw = 1'b1; mval = b; end
              mic_pkg::OP_LB: begin
                r.val = {{24{cur[lane*8+7]}}, cur[lane*8 +: 8]}; r.idx = rt; r.wr = 1'b1;
              end
              default: begin
                memw = 1'b1; mval = cur; mval[lane*8 +: 8] = b[7:0];
              end
            endcase
          end
        end
        mic_pkg::OP_BEQ: if (a == b) r.npc = target;
        mic_pkg::OP_BNE: if (a != b) r.npc = target;
        mic_pkg::OP_BLEZ, mic_pkg::OP_BGTZ: begin
          if (rt != 5'd0) begin
            r.status = mic_pkg::ST_ILLEGAL; r.npc = arch_pc;
          end else if ((op == mic_pkg::OP_BLEZ) == (a == 32'h0 || a[31])) r.npc = target;
        end
        mic_pkg::OP_REGIMM: begin
          case (rt)
            mic_pkg::RT_BLTZ: if (a[31]) r.npc = target;
            mic_pkg::RT_BGEZ: if (!a[31]) r.npc = target;
            mic_pkg::RT_BLTZAL, mic_pkg::RT_BGEZAL: begin
              // link is written whether or not the branch goes
              r.val = arch_pc + 32'd4; r.idx = mic_pkg::REG_RA; r.wr = 1'b1;
              if ((rt == mic_pkg::RT_BLTZAL) == a[31]) r.npc = target;
            end
            default: begin r.status = mic_pkg::ST_ILLEGAL; r.npc = arch_pc; end
          endcase
        end
        mic_pkg::OP_J, mic_pkg::OP_JAL: begin
          r.npc = ((arch_pc + 32'd4) & mic_pkg::JMP_MASK) | {4'h0, w[25:0], 2'b00};
          if (op == mic_pkg::OP_JAL) begin
            r.val = arch_pc + 32'd4; r.idx = mic_pkg::REG_RA; r.wr = 1'b1;
          end
        end
        default: begin r.status = mic_pkg::ST_ILLEGAL; r.npc = arch_pc; end
      endcase
    end
    if (!(r.wr && r.idx != mic_pkg::REG_ZERO)) begin
      r.wr = 1'b0; r.idx = '0; r.val = '0;
    end
    if (apply) begin
      if (r.status == mic_pkg::ST_EXIT || r.status == mic_pkg::ST_ILLEGAL ||
          r.status == mic_pkg::ST_FAULT)
        halted = 1'b1;
      if (r.wr) gpr[r.idx] = r.val;
      hi_q = nhi; lo_q = nlo;
      if (memw) dmem[widx] = mval;
      arch_pc = r.npc;
    end
  endtask

  // drive one request; gap drawn per request, quiet stretches with no gap
  task automatic issue(input logic [31:0] w, input bit known = 1'b0,
                       input logic [2:0] st = mic_pkg::ST_OK,
                       input logic [31:0] val = '0);
    int gap;
    outcome_t r;
    gap = ((sent / 40) % 3 == 0) ? 0 : int'($urandom_range(0, 8));
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    instruction <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    core_step(w, 1'b1, r);
    if (known) begin
      r.status = st; r.val = val;
    end
    pending_results.push_back(r);
    sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_set(input logic [0:0] idx, input logic [31:0] data);
    wait_drained();
    // let the core settle back to idle before the write
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_write <= 1'b1; cfg_index <= idx; cfg_data <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == mic_pkg::CFG_START_PC) arch_pc = data;
    else dbase = data;
  endtask

  function automatic logic [31:0] rand_word();
    int          cls;
    logic [4:0]  rs, rt, rd, sh;
    logic [15:0] imm;
    logic [5:0]  fns [24];
    logic [5:0]  ops [8];
    logic [5:0]  mem_ops [4];
    logic [4:0]  rts [4];
    fns = '{mic_pkg::FN_ADD, mic_pkg::FN_ADDU, mic_pkg::FN_SUB, mic_pkg::FN_SUBU,
            mic_pkg::FN_AND, mic_pkg::FN_OR, mic_pkg::FN_XOR, mic_pkg::FN_SLT,
            mic_pkg::FN_SLTU, mic_pkg::FN_SLL, mic_pkg::FN_SRL, mic_pkg::FN_SRA,
            mic_pkg::FN_SLLV, mic_pkg::FN_SRLV, mic_pkg::FN_SRAV, mic_pkg::FN_MULT,
            mic_pkg::FN_MULTU, mic_pkg::FN_DIV, mic_pkg::FN_DIVU, mic_pkg::FN_MFHI,
            mic_pkg::FN_MFLO, mic_pkg::FN_JR, mic_pkg::FN_BREAK, mic_pkg::FN_SYSCALL};
    ops = '{mic_pkg::OP_ADDI, mic_pkg::OP_ADDI_U, mic_pkg::OP_SLTI, mic_pkg::OP_SLTIU,
            mic_pkg::OP_ANDI, mic_pkg::OP_ORI, mic_pkg::OP_XORI, mic_pkg::OP_LUI};
    mem_ops = '{mic_pkg::OP_LW, mic_pkg::OP_SW, mic_pkg::OP_LB, mic_pkg::OP_SB};
    rts = '{mic_pkg::RT_BLTZ, mic_pkg::RT_BGEZ, mic_pkg::RT_BLTZAL, mic_pkg::RT_BGEZAL};
    rs = 5'($urandom); rt = 5'($urandom); rd = 5'($urandom); sh = 5'($urandom);
    imm = 16'($urandom);
    cls = int'($urandom_range(0, 99));
    if (cls < 40) return {mic_pkg::OP_SPECIAL, rs, rt, rd, sh, fns[$urandom_range(0, 23)]};
    if (cls < 65) return enc_i(ops[$urandom_range(0, 7)], rs, rt, imm);
    if (cls < 82) begin
      // mostly through the data pointer in r28, sometimes any base register
      if ($urandom_range(0, 3) != 0) begin
        rs = 5'd28;
        imm = 16'($urandom_range(0, DMEM_WORDS * 4 - 1));
      end else imm = 16'((dbase + $urandom_range(0, DMEM_WORDS * 4 - 1)) - gpr[rs]);
      cls = int'($urandom_range(0, 3));
      if (mem_ops[cls] == mic_pkg::OP_LW || mem_ops[cls] == mic_pkg::OP_SW)
        imm[1:0] = 2'b00;
      return enc_i(mem_ops[cls], rs, rt, imm);
    end
    if (cls < 86)
      return enc_i($urandom_range(0, 1) ? mic_pkg::OP_BEQ : mic_pkg::OP_BNE, rs, rt, imm);
    if (cls < 89)
      return enc_i($urandom_range(0, 1) ? mic_pkg::OP_BLEZ : mic_pkg::OP_BGTZ,
                   rs, 5'd0, imm);
    if (cls < 93) return enc_i(mic_pkg::OP_REGIMM, rs, rts[$urandom_range(0, 3)], imm);
    if (cls < 96)
      return {$urandom_range(0, 1) ? mic_pkg::OP_J : mic_pkg::OP_JAL, 26'($urandom)};
    return $urandom;
  endfunction

  // random word that keeps the core running and leaves the data pointer alone
  task automatic next_live_word(output logic [31:0] w);
    outcome_t r;
    for (int t = 0; t < 50; t++) begin
      w = rand_word();
      core_step(w, 1'b0, r);
      if (!(r.status == mic_pkg::ST_EXIT || r.status == mic_pkg::ST_ILLEGAL ||
            r.status == mic_pkg::ST_FAULT) &&
          !(r.wr && r.idx == 5'd28))
        return;
    end
    w = enc_r(mic_pkg::FN_SLL, 5'd0, 5'd0, 5'd0, 5'd0);
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
    $display("mismatch %s: got %h expected %h (result %0d)", what, got, exp, accepted);
    errors++;
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] exp);
    if (got !== exp) report(what, got, exp);
  endtask

  always @(posedge clk) begin
    outcome_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) report("unexpected result", next_pc, '0);
      else begin
        e = pending_results.pop_front();
        check_field("next_pc", next_pc, e.npc);
        check_field("status", 32'(status), 32'(e.status));
        check_field("service", service, e.service);
        check_field("argument", argument, e.argument);
        check_field("reg_written", 32'(reg_written), 32'(e.wr));
        check_field("reg_index", 32'(reg_index), 32'(e.idx));
        check_field("reg_value", reg_value, e.val);
        check_field("overflow", 32'(overflow), 32'(e.ovf));
        check_field("div_by_zero", 32'(div_by_zero), 32'(e.dz));
      end
      accepted++;
      stall_left = ((accepted / 30) % 3 == 1) ? 0 : int'($urandom_range(0, 8));
    end
  end

  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = 120;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else out_stall <= 1'b0;
    end
  end

  task automatic build_table();
    dir_rows = '{
      '{enc_i(mic_pkg::OP_LUI, 5'd0, 5'd28, 16'h1001), 1'b1, mic_pkg::ST_OK, 32'h10010000},
      '{enc_i(mic_pkg::OP_ADDI_U, 5'd0, 5'd1, 16'hFFFF), 1'b1, mic_pkg::ST_OK,
        32'hFFFFFFFF},
      '{enc_i(mic_pkg::OP_LUI, 5'd0, 5'd2, 16'h8000), 1'b1, mic_pkg::ST_OK, 32'h80000000},
      '{enc_r(mic_pkg::FN_ADD, 5'd2, 5'd2, 5'd3, 5'd0), 1'b1, mic_pkg::ST_OK, 32'h0},
      '{enc_i(mic_pkg::OP_ADDI, 5'd2, 5'd5, 16'hFFFF), 1'b0, mic_pkg::ST_OK, 32'h0},
      '{enc_r(mic_pkg::FN_SUB, 5'd0, 5'd2, 5'd4, 5'd0), 1'b0, mic_pkg::ST_OK, 32'h0},
      '{enc_r(mic_pkg::FN_SLT, 5'd2, 5'd1, 5'd6, 5'd0), 1'b1, mic_pkg::ST_OK, 32'h1},
      '{enc_r(mic_pkg::FN_SRA, 5'd0, 5'd2, 5'd8, 5'd31), 1'b1, mic_pkg::ST_OK,
        32'hFFFFFFFF},
      '{enc_r(mic_pkg::FN_SRLV, 5'd1, 5'd1, 5'd9, 5'd0), 1'b1, mic_pkg::ST_OK, 32'h1},
      '{enc_r(mic_pkg::FN_SLLV, 5'd1, 5'd1, 5'd10, 5'd0), 1'b1, mic_pkg::ST_OK,
        32'h80000000},
      '{enc_r(mic_pkg::FN_DIV, 5'd2, 5'd1, 5'd0, 5'd0), 1'b0, mic_pkg::ST_OK, 32'h0},
      '{enc_r(mic_pkg::FN_MFLO, 5'd0, 5'd0, 5'd11, 5'd0), 1'b1, mic_pkg::ST_OK,
        32'h80000000},
      '{enc_r(mic_pkg::FN_MFHI, 5'd0, 5'd0, 5'd12, 5'd0), 1'b1, mic_pkg::ST_OK, 32'h0},
      '{enc_r(mic_pkg::FN_DIVU, 5'd1, 5'd0, 5'd0, 5'd0), 1'b0, mic_pkg::ST_OK, 32'h0},
      '{enc_r(mic_pkg::FN_MULTU, 5'd1, 5'd1, 5'd0, 5'd0), 1'b0, mic_pkg::ST_OK, 32'h0},
      '{enc_r(mic_pkg::FN_MFHI, 5'd0, 5'd0, 5'd13, 5'd0), 1'b1, mic_pkg::ST_OK,
        32'hFFFFFFFE},
      '{enc_i(mic_pkg::OP_SW, 5'd28, 5'd1, 16'd4092), 1'b0, mic_pkg::ST_OK, 32'h0},
      '{enc_i(mic_pkg::OP_LB, 5'd28, 5'd14, 16'd4095), 1'b1, mic_pkg::ST_OK,
        32'hFFFFFFFF},
      '{enc_i(mic_pkg::OP_SB, 5'd28, 5'd2, 16'd1), 1'b0, mic_pkg::ST_OK, 32'h0},
      '{enc_i(mic_pkg::OP_LB, 5'd28, 5'd15, 16'd1), 1'b1, mic_pkg::ST_OK, 32'h0},
      '{enc_i(mic_pkg::OP_SLTIU, 5'd0, 5'd18, 16'hFFFF), 1'b1, mic_pkg::ST_OK, 32'h1},
      '{enc_i(mic_pkg::OP_XORI, 5'd1, 5'd16, 16'h8001), 1'b0, mic_pkg::ST_OK, 32'h0},
      '{enc_i(mic_pkg::OP_BEQ, 5'd0, 5'd0, 16'h0004), 1'b0, mic_pkg::ST_OK, 32'h0},
      '{enc_i(mic_pkg::OP_BNE, 5'd1, 5'd0, 16'hFFFF), 1'b0, mic_pkg::ST_OK, 32'h0},
      '{enc_i(mic_pkg::OP_BLEZ, 5'd2, 5'd0, 16'h7FFF), 1'b0, mic_pkg::ST_OK, 32'h0},
      '{enc_i(mic_pkg::OP_BGTZ, 5'd1, 5'd0, 16'h0010), 1'b0, mic_pkg::ST_OK, 32'h0},
      '{enc_i(mic_pkg::OP_REGIMM, 5'd2, mic_pkg::RT_BLTZ, 16'h8000), 1'b0,
        mic_pkg::ST_OK, 32'h0},
      '{enc_i(mic_pkg::OP_REGIMM, 5'd1, mic_pkg::RT_BLTZAL, 16'h0003), 1'b0,
        mic_pkg::ST_OK, 32'h0},
      '{enc_i(mic_pkg::OP_REGIMM, 5'd2, mic_pkg::RT_BGEZAL, 16'h0003), 1'b0,
        mic_pkg::ST_OK, 32'h0},
      '{{mic_pkg::OP_JAL, 26'h3FFFFFF}, 1'b0, mic_pkg::ST_OK, 32'h0},
      '{enc_r(mic_pkg::FN_JR, 5'd28, 5'd0, 5'd0, 5'd0), 1'b0, mic_pkg::ST_OK, 32'h0},
      '{enc_r(mic_pkg::FN_BREAK, 5'd0, 5'd0, 5'd0, 5'd0), 1'b0, mic_pkg::ST_OK, 32'h0},
      '{{mic_pkg::OP_SPECIAL, 20'hFFFFF, mic_pkg::FN_SYSCALL}, 1'b0, mic_pkg::ST_OK,
        32'h0}
    };
  endtask

  initial begin
    logic [31:0] w;
    logic [31:0] pcs [4];
    logic [31:0] bases [4];
    int          per_phase, tail;
    rst = 1'b1; in_valid = 1'b0; instruction = '0; out_stall = 1'b0;
    cfg_write = 1'b0; cfg_index = mic_pkg::CFG_START_PC; cfg_data = '0;
    errors = 0; sent = 0; accepted = 0; hold_req = 1'b0; hold_cnt = 0; stall_left = 0;
    arch_pc = mic_pkg::START_PC_RST; dbase = mic_pkg::DATA_BASE_RST;
    hi_q = '0; lo_q = '0; halted = 1'b0;
    for (int i = 0; i < 32; i++) gpr[i] = '0;
    for (int i = 0; i < DMEM_WORDS; i++) dmem[i] = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    cfg_set(mic_pkg::CFG_START_PC, mic_pkg::START_PC_RST);
    cfg_set(mic_pkg::CFG_DATA_BASE, mic_pkg::DATA_BASE_RST);
    build_table();
    foreach (dir_rows[i])
      issue(dir_rows[i].word, dir_rows[i].known, dir_rows[i].st, dir_rows[i].val);

    pcs = '{32'hFFFFFFFC, 32'h0, $urandom, mic_pkg::START_PC_RST};
    bases = '{32'h0, 32'hFFFFF000, $urandom, mic_pkg::DATA_BASE_RST};
    per_phase = 118;
    for (int ph = 0; ph < 4; ph++) begin
      cfg_set(mic_pkg::CFG_START_PC, pcs[ph]);
      cfg_set(mic_pkg::CFG_DATA_BASE, bases[ph]);
      issue(enc_i(mic_pkg::OP_LUI, 5'd0, 5'd28, bases[ph][31:16]));
      issue(enc_i(mic_pkg::OP_ORI, 5'd28, 5'd28, bases[ph][15:0]));
      for (int k = 0; k < per_phase; k++) begin
        if (ph == 1 && k == 20) hold_req = 1'b1;
        if (ph == 2 && k == 60) wait_drained();
        next_live_word(w);
        issue(w);
      end
    end

    // one halting case per run, then requests against the halted core
    tail = int'($urandom_range(0, 6));
    case (tail)
      0: issue({6'h3F, 26'($urandom)});
      1: issue(enc_r(6'h01, 5'd1, 5'd2, 5'd3, 5'd0));
      2: issue(enc_i(mic_pkg::OP_REGIMM, 5'd1, 5'h02, 16'h0001));
      3: issue(enc_i(mic_pkg::OP_BLEZ, 5'd0, 5'd1, 16'h0001));
      4: issue(enc_i(mic_pkg::OP_LW, 5'd28, 5'd1, 16'h0002));
      5: issue(enc_i(mic_pkg::OP_SW, 5'd28, 5'd1, 16'hFFFC));
      default: begin
        issue(enc_i(mic_pkg::OP_ADDI_U, 5'd0, mic_pkg::REG_V0, 16'd10));
        issue({mic_pkg::OP_SPECIAL, 20'h0, mic_pkg::FN_SYSCALL});
      end
    endcase
    repeat (4) issue($urandom);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      report("results never arrived", 32'(pending_results.size()), 32'd0);
    if (errors == 0) begin
      $display("tb_mips_integer_core_step_core passed");
    end else begin
      $display("tb_mips_integer_core_step_core failed");
    end
    $finish;
  end

endmodule
